/* rtl/pwmsc_pkg.sv */
package pwmsc_pkg;

  localparam int unsigned ClkW     = 32;
  localparam int unsigned FreqW    = 32;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned DutyOutW = 7;
  localparam int unsigned ReqFreqW = 20;

  localparam int unsigned DvdW     = 40;
  localparam int unsigned DvsW     = 32;
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [FreqW-1:0] FreqMin  = FreqW'(1);
  localparam logic [FreqW-1:0] FreqMax  = FreqW'(1000000);
  localparam logic [DutyW-1:0] DutyMax  = DutyW'(100);
  localparam logic [DutyW-1:0] DutyHalf = DutyW'(50);

  // reciprocals of 100 for period / 100 and for the small remainder term
  localparam int unsigned    QuoHW          = 26;
  localparam int unsigned    RemHW          = 7;
  localparam int unsigned    LoW            = 14;
  localparam int unsigned    LoProdW        = 2 * LoW;
  localparam int unsigned    RecipHundredSh = 38;
  localparam int unsigned    RecipLowSh     = 20;
  localparam logic [31:0]    RecipHundred   = 32'd2748779070;
  localparam logic [LoW-1:0] RecipLow       = LoW'(10486);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_BAD_FREQ = 2'd2,
    ST_BAD_DUTY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PERIOD_WAIT,
    S_PULSE_RECIP,
    S_PULSE_REM,
    S_PULSE_PROD,
    S_PULSE_SUM,
    S_DUTY_MUL,
    S_DUTY_START,
    S_DUTY_WAIT,
    S_FREQ_WAIT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/pwmsc_divider.sv */
module pwmsc_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwmsc_pkg::div_req_t req_i,
  output pwmsc_pkg::div_rsp_t rsp_o
);
  import pwmsc_pkg::*;

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivSteps - 1);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsW-1:0]    rem_q;
  logic [DvdW-1:0]    quo_q;
  logic [DvsW-1:0]    dvs_q;

  logic [DvsW:0]      rem_sh;
  logic               ge;
  logic [DvsW:0]      diff;

  assign rem_sh = {rem_q, quo_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DvsW-1:0] : rem_sh[DvsW-1:0];
      quo_q <= {quo_q[DvdW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/pwm_setpoint_calculator.sv */
// pwm setpoint calculator
// turns a frequency / duty request into timer period and compare counts,
// using the counter clock held in the configuration register.
// input channel: in_valid_i / in_stall_o with frequency_hz_i and duty_request_i;
// a transaction is taken when valid is high and stall is low.
// output channel: out_valid_o / out_stall_i; one result per request carrying
// the status and the stored setpoint (rejected requests leave it unchanged).
// configuration: cfg_we_i writes cfg_wdata_i as the counter clock; write
// only while no request is in flight.
// a request failing the range checks goes from S_CHECK straight to the result;
// one whose period rounds to zero gives its result after the period division,
// an accepted one after three passes of the shared radix-2 divider plus the
// multiply steps of the compare count.
// one request at a time: in_stall_o stays high from acceptance until the
// result has been taken, so no new request is taken while one is in flight.
// while out_stall_i is high the result is held stable on the output ports.
// reset clears the counter clock, the stored setpoint and the status to zero.
module pwm_setpoint_calculator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pwmsc_pkg::ClkW-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pwmsc_pkg::FreqW-1:0]         frequency_hz_i,
  input  logic [pwmsc_pkg::DutyW-1:0]         duty_request_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [31:0]                         period_count_o,
  output logic [31:0]                         compare_count_o,
  output logic [31:0]                         actual_frequency_o,
  output logic [pwmsc_pkg::DutyOutW-1:0]      duty_actual_o,
  output logic [pwmsc_pkg::ReqFreqW-1:0]      requested_frequency_o
);
  import pwmsc_pkg::*;

  state_e              state_q, state_d;
  status_e             status_q;
  logic [ClkW-1:0]     clk_hz_q;
  logic [FreqW-1:0]    freq_q;
  logic [DutyW-1:0]    duty_q;
  logic [31:0]         period_w_q;
  logic [31:0]         pulse_w_q;
  logic [DutyOutW-1:0] qduty_w_q;
  logic [DvdW-1:0]     prod_q;
  logic [QuoHW-1:0]    quo_h_q;
  logic [RemHW-1:0]    rem_h_q;
  logic [31:0]         pulse_hi_q;
  logic [LoW-1:0]      pulse_lo_q;

  logic [31:0]         held_period_q;
  logic [31:0]         held_compare_q;
  logic [31:0]         held_freq_q;
  logic [DutyOutW-1:0] held_duty_q;
  logic [ReqFreqW-1:0] held_req_q;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  status_e             check_status;
  logic                check_err;

  logic [63:0]         recip_prod;
  logic [31:0]         hund_x100;
  logic [31:0]         rem_full;
  logic [LoProdW-1:0]  lo_prod;

  pwmsc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    check_status = ST_OK;
    if (clk_hz_q == '0) begin
      check_status = ST_NOT_INIT;
    end else if (freq_q < FreqMin || freq_q > FreqMax) begin
      check_status = ST_BAD_FREQ;
    end else if (duty_q > DutyMax) begin
      check_status = ST_BAD_DUTY;
    end
  end

  assign check_err = (check_status != ST_OK);

  // period split as 100 * quotient + remainder for the compare count
  assign recip_prod = 64'(period_w_q) * 64'(RecipHundred);
  assign hund_x100  = (32'(quo_h_q) << 6) + (32'(quo_h_q) << 5) + (32'(quo_h_q) << 2);
  assign rem_full   = period_w_q - hund_x100;
  assign lo_prod    = LoProdW'(pulse_lo_q) * LoProdW'(RecipLow);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (check_err) begin
          state_d = S_RESULT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(clk_hz_q) + DvdW'(freq_q >> 1);
          div_req.divisor  = DvsW'(freq_q);
          state_d          = S_PERIOD_WAIT;
        end
      end
      S_PERIOD_WAIT: begin
        if (div_rsp.done) begin
          state_d = (div_rsp.quotient == '0) ? S_RESULT : S_PULSE_RECIP;
        end
      end
      S_PULSE_RECIP: state_d = S_PULSE_REM;
      S_PULSE_REM: state_d = S_PULSE_PROD;
      S_PULSE_PROD: state_d = S_PULSE_SUM;
      S_PULSE_SUM: state_d = S_DUTY_MUL;
      S_DUTY_MUL: state_d = S_DUTY_START;
      S_DUTY_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q + DvdW'(period_w_q >> 1);
        div_req.divisor  = period_w_q;
        state_d          = S_DUTY_WAIT;
      end
      S_DUTY_WAIT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DvdW'(clk_hz_q);
          div_req.divisor  = period_w_q;
          state_d          = S_FREQ_WAIT;
        end
      end
      S_FREQ_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= '0;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_wdata_i;
    end
  end

  // stored setpoint and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q       <= ST_OK;
      held_period_q  <= '0;
      held_compare_q <= '0;
      held_freq_q    <= '0;
      held_duty_q    <= '0;
      held_req_q     <= '0;
    end else begin
      case (state_q)
        S_CHECK: begin
          if (check_err) begin
            status_q <= check_status;
          end
        end
        S_PERIOD_WAIT: begin
          if (div_rsp.done && div_rsp.quotient == '0) begin
            status_q <= ST_BAD_FREQ;
          end
        end
        S_FREQ_WAIT: begin
          if (div_rsp.done) begin
            status_q       <= ST_OK;
            held_period_q  <= period_w_q;
            held_compare_q <= pulse_w_q;
            held_freq_q    <= div_rsp.quotient[31:0];
            held_duty_q    <= qduty_w_q;
            held_req_q     <= freq_q[ReqFreqW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      freq_q <= frequency_hz_i;
      duty_q <= duty_request_i;
    end
    if (state_q == S_PERIOD_WAIT && div_rsp.done) begin
      period_w_q <= div_rsp.quotient[31:0];
    end
    if (state_q == S_PULSE_RECIP) begin
      quo_h_q <= recip_prod[RecipHundredSh +: QuoHW];
    end
    if (state_q == S_PULSE_REM) begin
      rem_h_q <= rem_full[RemHW-1:0];
    end
    if (state_q == S_PULSE_PROD) begin
      pulse_hi_q <= 32'(quo_h_q) * 32'(duty_q);
      pulse_lo_q <= LoW'(rem_h_q) * LoW'(duty_q) + LoW'(DutyHalf);
    end
    if (state_q == S_PULSE_SUM) begin
      pulse_w_q <= pulse_hi_q + 32'(lo_prod[RecipLowSh +: RemHW]);
    end
    if (state_q == S_DUTY_MUL) begin
      // times 100 as 64 + 32 + 4
      prod_q <= (DvdW'(pulse_w_q) << 6) + (DvdW'(pulse_w_q) << 5) + (DvdW'(pulse_w_q) << 2);
    end
    if (state_q == S_DUTY_WAIT && div_rsp.done) begin
      qduty_w_q <= div_rsp.quotient[DutyOutW-1:0];
    end
  end

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = (state_q == S_RESULT);
  assign status_o              = status_q;
  assign period_count_o        = held_period_q;
  assign compare_count_o       = held_compare_q;
  assign actual_frequency_o    = held_freq_q;
  assign duty_actual_o         = held_duty_q;
  assign requested_frequency_o = held_req_q;

`ifndef SYNTH
  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_CHECK)
    else $error("accepted transaction not checked");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_PERIOD_WAIT || state_q == S_DUTY_WAIT ||
                      state_q == S_FREQ_WAIT))
    else $error("divider finished outside a wait state");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
                                      $stable(period_count_o)))
    else $error("stalled result changed");
`endif

endmodule
